>>> sv/color_packet_ratio_decoder_defines.svh
// assertion macros for the color packet ratio decoder
// used by cprd_ctrl, no other dependencies
`ifndef COLOR_PACKET_RATIO_DECODER_DEFINES_SVH
`define COLOR_PACKET_RATIO_DECODER_DEFINES_SVH

// same-cycle implication
`define CPRD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cprd: same-cycle check failed");

// next-cycle implication
`define CPRD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cprd: next-cycle check failed");

`endif

>>> sv/cprd_pkg.sv
// shared types, constants and codes for the color packet ratio decoder
// no dependencies
`timescale 1ns / 1ps

package cprd_pkg;

  localparam int MAX_SENSORS   = 16;
  localparam int FRACTION_BITS = 8;

  localparam int SLOTS       = 8;
  localparam int SLOT_W      = 7;
  localparam int SLOT_IDX_W  = 3;
  localparam int ROW_W       = SLOTS * SLOT_W;
  localparam int COLOR_W     = 2 * SLOT_W;
  localparam int SCALE       = 1000;
  localparam int SCALE_W     = 10;
  localparam int PROD_W      = COLOR_W + SCALE_W;
  localparam int NUM_W       = PROD_W + FRACTION_BITS;
  localparam int DIV_CNT_W   = $clog2(NUM_W + 1);
  localparam int RATIO_W     = 32;
  localparam int SID_W       = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
  localparam int N_W         = 8;
  localparam int SENSOR_ID_W = 4;

  localparam logic [7:0] STATUS_MASK = 8'hF0;
  localparam logic [7:0] STATUS_CC   = 8'hB0;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] REG_BROADCAST_ALL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_COUNT  = 1'd1;

  localparam logic [1:0] SEL_RED   = 2'd0;
  localparam logic [1:0] SEL_GREEN = 2'd1;
  localparam logic [1:0] SEL_BLUE  = 2'd2;

  typedef struct packed {
    logic [7:0] status_byte;
    logic [4:0] channel_number;
    logic [6:0] sensor_index;
    logic [6:0] data_value;
  } in_item_t;

  typedef struct packed {
    logic [SENSOR_ID_W-1:0] sensor_id;
    logic [RATIO_W-1:0]     red_ratio;
    logic [RATIO_W-1:0]     green_ratio;
    logic [RATIO_W-1:0]     blue_ratio;
    logic                   clear_zero;
    logic                   last_result;
  } out_item_t;

  typedef struct packed {
    logic       latch_msg;
    logic       mem_read;
    logic       mem_write;
    logic       sensor_next;
    logic       num_load;
    logic       div_start;
    logic       ratio_store;
    logic [1:0] color_sel;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic msg_ok;
    logic is_chan8;
    logic at_last;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

>>> sv/color_packet_ratio_decoder.sv
// a message that fails its checks stores nothing; channels 1 to 7 update one row per sensor
// channel 8 completes a packet: after the write the shared divider runs, one quotient bit
// per cycle, three times per sensor, once per color; each result may then wait for the output
// one message is processed at a time; the next is taken while the last result waits
// reset: synchronous; clears config, row valid bits and control, no clearing pass needed
// depends on cprd_pkg, cprd_ctrl and cprd_dp
`timescale 1ns / 1ps

module color_packet_ratio_decoder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [cprd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cprd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  cprd_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output cprd_pkg::out_item_t             out_data
);

  cprd_pkg::cmd_t    cmd;
  cprd_pkg::status_t stat;

  cprd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cprd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> sv/cprd_div.sv
// restoring divider, one quotient bit per cycle
// depends on cprd_pkg
`timescale 1ns / 1ps

module cprd_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [cprd_pkg::NUM_W-1:0]    dividend,
  input  logic [cprd_pkg::COLOR_W-1:0]  divisor,
  output logic                          busy,
  output logic                          done,
  output logic [cprd_pkg::NUM_W-1:0]    quotient
);

  logic [cprd_pkg::COLOR_W-1:0]   rem;
  logic [cprd_pkg::DIV_CNT_W-1:0] cnt;
  logic [cprd_pkg::COLOR_W:0]     shifted;
  logic                           fits;

  assign shifted = {rem, quotient[cprd_pkg::NUM_W-1]};
  assign fits    = (shifted >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= cprd_pkg::DIV_CNT_W'(cprd_pkg::NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == cprd_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
    end else if (busy) begin
      if (fits) begin
        rem <= cprd_pkg::COLOR_W'(shifted - {1'b0, divisor});
      end else begin
        rem <= shifted[cprd_pkg::COLOR_W-1:0];
      end
      quotient <= {quotient[cprd_pkg::NUM_W-2:0], fits};
    end
  end

endmodule

>>> sv/cprd_dp.sv
// datapath: config registers, packet row memory, divider and output register
// depends on cprd_pkg and cprd_div
`timescale 1ns / 1ps

module cprd_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [cprd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cprd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  cprd_pkg::in_item_t              in_data,
  input  cprd_pkg::cmd_t                  cmd,
  output cprd_pkg::status_t               stat,
  output logic                            out_valid,
  input  logic                            out_ready,
  output cprd_pkg::out_item_t             out_data
);

  localparam int QW = (cprd_pkg::NUM_W > cprd_pkg::RATIO_W) ? cprd_pkg::NUM_W
                                                              : cprd_pkg::RATIO_W + 1;

  logic                           broadcast_all;
  logic [cprd_pkg::CFG_DATA_W-1:0] sensor_count;

  logic [cprd_pkg::ROW_W-1:0] mem [cprd_pkg::MAX_SENSORS];
  logic [cprd_pkg::MAX_SENSORS-1:0] vld;
  logic [cprd_pkg::ROW_W-1:0] rdata;
  logic                       rvld;
  logic [cprd_pkg::ROW_W-1:0] row;
  logic [cprd_pkg::ROW_W-1:0] new_row;

  logic [cprd_pkg::SID_W-1:0]      s;
  logic [cprd_pkg::SID_W-1:0]      last_s;
  logic [cprd_pkg::SLOT_IDX_W-1:0] slot;
  logic [cprd_pkg::SLOT_W-1:0]     val;
  logic                            chan8;
  logic                            msg_ok;

  logic [cprd_pkg::N_W-1:0]   n_use;
  logic                       dec_ok;
  logic [cprd_pkg::SID_W-1:0] dec_first;
  logic [cprd_pkg::SID_W-1:0] dec_last;

  logic [cprd_pkg::COLOR_W-1:0] color;
  logic [cprd_pkg::COLOR_W-1:0] clear_val;
  logic                         clear_zero;
  logic [cprd_pkg::PROD_W-1:0]  prod;
  logic [cprd_pkg::NUM_W-1:0]   num;
  logic                         div_busy;
  logic                         div_done;
  logic [cprd_pkg::NUM_W-1:0]   quotient;
  logic [QW-1:0]                q_ext;
  logic [cprd_pkg::RATIO_W-1:0] ratio_val;
  logic [cprd_pkg::RATIO_W-1:0] red_r;
  logic [cprd_pkg::RATIO_W-1:0] green_r;
  logic [cprd_pkg::RATIO_W-1:0] blue_r;

  // message decode
  always_comb begin
    if (cprd_pkg::N_W'(sensor_count) > cprd_pkg::N_W'(cprd_pkg::MAX_SENSORS)) begin
      n_use = cprd_pkg::N_W'(cprd_pkg::MAX_SENSORS);
    end else begin
      n_use = cprd_pkg::N_W'(sensor_count);
    end
    dec_ok = ((in_data.status_byte & cprd_pkg::STATUS_MASK) == cprd_pkg::STATUS_CC) &&
             (in_data.channel_number >= 5'd1) &&
             (in_data.channel_number <= 5'(cprd_pkg::SLOTS));
    if (broadcast_all) begin
      dec_ok    = dec_ok && (n_use != '0);
      dec_first = '0;
      dec_last  = cprd_pkg::SID_W'(n_use - 1'b1);
    end else begin
      dec_ok    = dec_ok && (cprd_pkg::N_W'(in_data.sensor_index) < n_use);
      dec_first = cprd_pkg::SID_W'(in_data.sensor_index);
      dec_last  = cprd_pkg::SID_W'(in_data.sensor_index);
    end
  end

  // slot update of the fetched row
  always_comb begin
    new_row = rvld ? rdata : '0;
    for (int i = 0; i < cprd_pkg::SLOTS; i++) begin
      if (slot == cprd_pkg::SLOT_IDX_W'(i)) begin
        new_row[i*cprd_pkg::SLOT_W +: cprd_pkg::SLOT_W] = val;
      end
    end
  end

  assign clear_val  = row[3*cprd_pkg::COLOR_W +: cprd_pkg::COLOR_W];
  assign clear_zero = (clear_val == '0);

  always_comb begin
    case (cmd.color_sel)
      cprd_pkg::SEL_RED:   color = row[0 +: cprd_pkg::COLOR_W];
      cprd_pkg::SEL_GREEN: color = row[cprd_pkg::COLOR_W +: cprd_pkg::COLOR_W];
      cprd_pkg::SEL_BLUE:  color = row[2*cprd_pkg::COLOR_W +: cprd_pkg::COLOR_W];
      default:             color = '0;
    endcase
  end

  assign prod = cprd_pkg::PROD_W'(color) * cprd_pkg::PROD_W'(cprd_pkg::SCALE);

  assign q_ext = QW'(quotient);

  always_comb begin
    if (clear_zero || (|q_ext[QW-1:cprd_pkg::RATIO_W])) begin
      ratio_val = '1;
    end else begin
      ratio_val = q_ext[cprd_pkg::RATIO_W-1:0];
    end
  end

  cprd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (num),
    .divisor  (clear_val),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quotient)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      broadcast_all <= 1'b0;
      sensor_count  <= '0;
      vld           <= '0;
      msg_ok        <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          cprd_pkg::REG_BROADCAST_ALL: broadcast_all <= cfg_data[0];
          cprd_pkg::REG_SENSOR_COUNT:  sensor_count  <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.latch_msg) begin
        msg_ok <= dec_ok;
      end
      if (cmd.mem_write) begin
        vld[s] <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // row memory
  always_ff @(posedge clk) begin
    if (cmd.mem_write) begin
      mem[s] <= new_row;
    end
    if (cmd.mem_read) begin
      rdata <= mem[s];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch_msg) begin
      s      <= dec_first;
      last_s <= dec_last;
      slot   <= cprd_pkg::SLOT_IDX_W'(in_data.channel_number - 5'd1);
      val    <= in_data.data_value;
      chan8  <= (in_data.channel_number == 5'(cprd_pkg::SLOTS));
    end else if (cmd.sensor_next) begin
      s <= s + 1'b1;
    end
    if (cmd.mem_read) begin
      rvld <= vld[s];
    end
    if (cmd.mem_write) begin
      row <= new_row;
    end
    if (cmd.num_load) begin
      num <= cprd_pkg::NUM_W'(prod) << cprd_pkg::FRACTION_BITS;
    end
    if (cmd.ratio_store) begin
      case (cmd.color_sel)
        cprd_pkg::SEL_RED:   red_r   <= ratio_val;
        cprd_pkg::SEL_GREEN: green_r <= ratio_val;
        default:             blue_r  <= ratio_val;
      endcase
    end
    if (cmd.out_load) begin
      out_data.sensor_id   <= cprd_pkg::SENSOR_ID_W'(s);
      out_data.red_ratio   <= red_r;
      out_data.green_ratio <= green_r;
      out_data.blue_ratio  <= blue_r;
      out_data.clear_zero  <= clear_zero;
      out_data.last_result <= (s == last_s);
    end
  end

  assign stat.msg_ok   = msg_ok;
  assign stat.is_chan8 = chan8;
  assign stat.at_last  = (s == last_s);
  assign stat.div_done = div_done && !div_busy;
  assign stat.out_free = !out_valid || out_ready;

endmodule

>>> sv/cprd_ctrl.sv
// controller state machine sequencing memory access, divisions and output
// depends on cprd_pkg and color_packet_ratio_decoder_defines.svh
`timescale 1ns / 1ps
`include "color_packet_ratio_decoder_defines.svh"

module cprd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  cprd_pkg::status_t stat,
  output cprd_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_MOD   = 3'd3;
  localparam logic [2:0] S_LOAD  = 3'd4;
  localparam logic [2:0] S_START = 3'd5;
  localparam logic [2:0] S_DIV   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [1:0] sel;
  logic [1:0] sel_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    sel_next   = sel;
    cmd        = '0;
    cmd.color_sel = sel;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_msg = 1'b1;
          state_next    = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = stat.msg_ok ? S_READ : S_IDLE;
      end
      S_READ: begin
        cmd.mem_read = 1'b1;
        state_next   = S_MOD;
      end
      S_MOD: begin
        cmd.mem_write = 1'b1;
        if (stat.is_chan8) begin
          sel_next   = cprd_pkg::SEL_RED;
          state_next = S_LOAD;
        end else if (stat.at_last) begin
          state_next = S_IDLE;
        end else begin
          cmd.sensor_next = 1'b1;
          state_next      = S_READ;
        end
      end
      S_LOAD: begin
        cmd.num_load = 1'b1;
        state_next   = S_START;
      end
      S_START: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.ratio_store = 1'b1;
          if (sel == cprd_pkg::SEL_BLUE) begin
            state_next = S_OUT;
          end else begin
            sel_next   = sel + 1'b1;
            state_next = S_LOAD;
          end
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          if (stat.at_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.sensor_next = 1'b1;
            state_next      = S_READ;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel   <= cprd_pkg::SEL_RED;
    end else begin
      state <= state_next;
      sel   <= sel_next;
    end
  end

  `CPRD_ASSERT_NOW(a_done_while_waiting, clk, rst, stat.div_done, state == S_DIV)
  `CPRD_ASSERT_NEXT(a_idle_after_last_out, clk, rst, cmd.out_load && stat.at_last, in_ready)
  `CPRD_ASSERT_NEXT(a_idle_after_last_store, clk, rst,
                    cmd.mem_write && !stat.is_chan8 && stat.at_last, in_ready)

endmodule
